>>> design/channel_sample_mean_std_monitor_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the channel sample mean and deviation monitor.
// Both expect signals named clk and rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_SAMPLE_MEAN_STD_MONITOR_UNIT_MACROS_SVH
`define CHANNEL_SAMPLE_MEAN_STD_MONITOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define CMSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define CMSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CMSM_ASSERT_IMP(lbl, ante, cons, msg)
`define CMSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/cmsm_pkg.sv
// ----------------------------------------------------------------------------
// cmsm_pkg
// Types, constants and widths shared by the monitor's modules.
// ----------------------------------------------------------------------------
package cmsm_pkg;

    localparam int NUM_CHANNELS_DEF = 48;
    localparam int NUM_GAINS_DEF    = 2;
    localparam int MAX_WINDOW       = 128;
    localparam int SAMPLE_LIMIT     = 4096;
    localparam int CHAN_EN_W        = 48;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int VAL_W  = $clog2(SAMPLE_LIMIT);
    localparam int SUM_W  = VAL_W + CNT_W - 1;
    localparam int SQ_W   = 2 * VAL_W + CNT_W - 1;
    localparam int Q_W    = 21;
    localparam int PAIR_W = 7;
    localparam int DIV_W  = 56;
    localparam int DEN_W  = 2 * CNT_W - 2;
    localparam int QUEUE_DEPTH = 4;

    localparam int Q_MAX_INT = 1048575;
    localparam logic signed [Q_W-1:0] Q_MAX  = Q_W'(Q_MAX_INT);
    localparam logic signed [Q_W-1:0] Q_NONE = -21'sd256;

    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_READ     = 1'b1;
    localparam logic KIND_STATS   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        CFG_GAIN_EN,
        CFG_CHAN_EN,
        CFG_WIN_START,
        CFG_WIN_END
    } cfg_reg_e;

    typedef enum logic {
        OP_READ,
        OP_SAMPLE
    } op_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_CLOSE,
        ST_MEAN,
        ST_MUL,
        ST_DIFF,
        ST_VAR,
        ST_SQRT,
        ST_UPDATE,
        ST_OUT
    } state_e;

    typedef struct packed {
        op_e              op;
        logic             gain;
        logic [5:0]       channel;
        logic [PAIR_W-1:0] pair;
        logic             good;
        logic             last;
        logic [VAL_W-1:0] value;
    } queue_entry_t;

    typedef struct packed {
        logic [SUM_W-1:0]        sum;
        logic [SQ_W-1:0]         sq;
        logic [CNT_W-1:0]        cnt;
        logic signed [Q_W-1:0]   mean_min;
        logic signed [Q_W-1:0]   mean_max;
        logic signed [Q_W-1:0]   std_min;
        logic signed [Q_W-1:0]   std_max;
    } stat_rec_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> design/cmsm_if.sv
// ----------------------------------------------------------------------------
// cmsm interfaces
// Valid/ready channels for sample items, result items and register writes.
// ----------------------------------------------------------------------------
interface cmsm_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic               gain_select;
    logic [5:0]         channel;
    logic [6:0]         sample_index;
    logic signed [15:0] sample_value;
    logic               last_sample;

    modport source (output valid, command, gain_select, channel, sample_index,
                    sample_value, last_sample, input ready);
    modport sink   (input valid, command, gain_select, channel, sample_index,
                    sample_value, last_sample, output ready);
endinterface

interface cmsm_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic               out_gain;
    logic [5:0]         out_channel;
    logic signed [20:0] mean_value;
    logic signed [20:0] std_value;
    logic signed [20:0] mean_min;
    logic signed [20:0] mean_max;
    logic signed [20:0] std_min;
    logic signed [20:0] std_max;

    modport source (output valid, result_kind, out_gain, out_channel, mean_value,
                    std_value, mean_min, mean_max, std_min, std_max, input ready);
    modport sink   (input valid, result_kind, out_gain, out_channel, mean_value,
                    std_value, mean_min, mean_max, std_min, std_max, output ready);
endinterface

interface cmsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/cmsm_front.sv
// ----------------------------------------------------------------------------
// cmsm_front
// Holds the configuration registers, accepts items and classifies them.
// ----------------------------------------------------------------------------
module cmsm_front #(
    parameter int NUM_CHANNELS = cmsm_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_GAINS    = cmsm_pkg::NUM_GAINS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    cmsm_in_if.sink                stream,
    cmsm_cfg_if.sink               cfg,
    output logic                   push,
    output cmsm_pkg::queue_entry_t push_data,
    input  logic                   full
);
    import cmsm_pkg::*;

    logic [1:0]           gain_en_reg;
    logic [CHAN_EN_W-1:0] chan_en_reg;
    logic [6:0]           win_start_reg;
    logic [7:0]           win_end_reg;

    logic in_range, enabled, in_window, value_ok, good;

    assign cfg.ready    = 1'b1;
    assign stream.ready = !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_en_reg   <= 2'b11;
            chan_en_reg   <= '1;
            win_start_reg <= '0;
            win_end_reg   <= 8'd128;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_e'(cfg.index))
                CFG_GAIN_EN:   gain_en_reg   <= cfg.data[1:0];
                CFG_CHAN_EN:   chan_en_reg   <= cfg.data[CHAN_EN_W-1:0];
                CFG_WIN_START: win_start_reg <= cfg.data[6:0];
                CFG_WIN_END:   win_end_reg   <= cfg.data[7:0];
            endcase
        end
    end

    always_comb
    begin
        in_range  = ({1'b0, stream.gain_select} < 2'(NUM_GAINS))
                 && ({1'b0, stream.channel} < 7'(NUM_CHANNELS));
        enabled   = gain_en_reg[stream.gain_select]
                 && (stream.channel < 6'(CHAN_EN_W))
                 && chan_en_reg[stream.channel];
        in_window = (stream.sample_index >= win_start_reg)
                 && ({1'b0, stream.sample_index} < win_end_reg);
        value_ok  = !stream.sample_value[15]
                 && (stream.sample_value[14:0] < 15'(SAMPLE_LIMIT));
        good      = in_window && value_ok;

        push_data.op      = (stream.command == CMD_READ) ? OP_READ : OP_SAMPLE;
        push_data.gain    = stream.gain_select;
        push_data.channel = stream.channel;
        push_data.pair    = stream.gain_select
                          ? PAIR_W'(NUM_CHANNELS) + {1'b0, stream.channel}
                          : {1'b0, stream.channel};
        push_data.good    = good;
        push_data.last    = stream.last_sample;
        push_data.value   = stream.sample_value[VAL_W-1:0];

        // Items that change nothing and give no result never reach the queue.
        push = stream.valid && !full && in_range
            && ((stream.command == CMD_READ)
                || (enabled && (good || stream.last_sample)));
    end

endmodule

>>> design/cmsm_fifo.sv
// ----------------------------------------------------------------------------
// cmsm_fifo
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
`include "channel_sample_mean_std_monitor_unit_macros.svh"

module cmsm_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cmsm_pkg::queue_entry_t push_data,
    output logic                   full,
    input  logic                   pop,
    output cmsm_pkg::queue_entry_t head,
    output logic                   empty
);
    import cmsm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    queue_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `CMSM_ASSERT_IMP(a_no_pop_empty, pop, !empty, "queue popped while empty")
    `CMSM_ASSERT_IMP(a_no_push_full, push, !full, "queue pushed while full")
    `CMSM_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "pushed item lost")

endmodule

>>> design/cmsm_div.sv
// ----------------------------------------------------------------------------
// cmsm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmsm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cmsm_pkg::div_req_t req,
    output cmsm_pkg::div_rsp_t rsp
);
    import cmsm_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg, done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DEN_W-1:0]  rem_reg, den_reg;
    logic [DEN_W:0]    trial;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIV_W-1]};
        ge    = (trial >= {1'b0, den_reg});
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
        end
    end

endmodule

>>> design/cmsm_back.sv
// ----------------------------------------------------------------------------
// cmsm_back
// Executes queued items against the per-pair statistics memory.
// ----------------------------------------------------------------------------
`include "channel_sample_mean_std_monitor_unit_macros.svh"

module cmsm_back #(
    parameter int NUM_CHANNELS = cmsm_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_GAINS    = cmsm_pkg::NUM_GAINS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmsm_pkg::queue_entry_t head,
    input  logic                   empty,
    output logic                   pop,
    cmsm_out_if.source             result
);
    import cmsm_pkg::*;

    localparam int PAIRS   = NUM_GAINS * NUM_CHANNELS;
    localparam int PAIR_AW = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    localparam stat_rec_t RESET_REC = '{sum: '0, sq: '0, cnt: '0,
                                        mean_min: Q_MAX, mean_max: Q_NONE,
                                        std_min: Q_MAX, std_max: Q_NONE};

    function automatic logic signed [Q_W-1:0] sat_q(input logic [DIV_W-1:0] v);
        sat_q = (v > DIV_W'(Q_MAX_INT)) ? Q_MAX : v[Q_W-1:0];
    endfunction

    state_e state_reg, state_next;

    stat_rec_t          stat_mem [PAIRS];
    logic [PAIRS-1:0]   vld_reg;
    stat_rec_t          rec_reg, rec_eff, wdata;
    logic               rec_vld_reg;
    logic               mem_we;

    queue_entry_t       ent_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [SUM_W-1:0]   s_reg;
    logic [SQ_W-1:0]    q_reg;
    logic signed [Q_W-1:0] mean_reg, std_reg;
    logic signed [Q_W-1:0] mn_reg, mx_reg, sn_reg, sx_reg;
    logic signed [Q_W-1:0] mn_new, mx_new, sn_new, sx_new;
    logic [CNT_W+SQ_W-1:0] pa_reg, pb_reg;
    logic [DEN_W-1:0]   d_reg;
    logic [DIV_W-1:0]   v_reg, root_reg, bit_reg, trial;
    logic               root_ge;

    logic               acc_ok;
    logic [2*VAL_W-1:0] sq_term;
    logic [SUM_W-1:0]   sum_new;
    logic [SQ_W-1:0]    sq_new;
    logic [CNT_W-1:0]   cnt_new;

    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic               load;
    logic               out_valid_reg;
    logic               kind_reg;

    cmsm_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    // Datapath terms used by several states.
    always_comb
    begin
        rec_eff = rec_vld_reg ? rec_reg : RESET_REC;
        acc_ok  = ent_reg.good && (rec_eff.cnt < CNT_W'(MAX_WINDOW));
        sq_term = ent_reg.value * ent_reg.value;
        sum_new = acc_ok ? rec_eff.sum + SUM_W'(ent_reg.value) : rec_eff.sum;
        sq_new  = acc_ok ? rec_eff.sq + SQ_W'(sq_term) : rec_eff.sq;
        cnt_new = acc_ok ? rec_eff.cnt + 1'b1 : rec_eff.cnt;
        trial   = root_reg + bit_reg;
        root_ge = (v_reg >= trial);
        mn_new  = (mean_reg < mn_reg) ? mean_reg : mn_reg;
        mx_new  = (mean_reg > mx_reg) ? mean_reg : mx_reg;
        sn_new  = (std_reg < sn_reg) ? std_reg : sn_reg;
        sx_new  = (std_reg > sx_reg) ? std_reg : sx_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (!empty) state_next = ST_READ;
            ST_READ:   state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (ent_reg.op == OP_READ)
                begin
                    state_next = ST_OUT;
                end
                else if (ent_reg.last)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLOSE:  state_next = (n_reg == '0) ? ST_UPDATE : ST_MEAN;
            ST_MEAN:
            begin
                if (div_rsp.done)
                begin
                    state_next = (n_reg < CNT_W'(2)) ? ST_UPDATE : ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_VAR;
            ST_VAR:    if (div_rsp.done) state_next = ST_SQRT;
            ST_SQRT:   if (bit_reg[0]) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_OUT;
            ST_OUT:    if (load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop          = 1'b0;
        mem_we       = 1'b0;
        wdata        = rec_eff;
        div_req      = '0;
        load         = 1'b0;
        unique case (state_reg)
            ST_IDLE:   pop = !empty;
            ST_EXEC:
            begin
                mem_we    = (ent_reg.op == OP_SAMPLE) && !ent_reg.last;
                wdata.sum = sum_new;
                wdata.sq  = sq_new;
                wdata.cnt = cnt_new;
            end
            ST_CLOSE:
            begin
                div_req.start    = (n_reg != '0);
                div_req.dividend = DIV_W'({s_reg, 8'h00});
                div_req.divisor  = DEN_W'(n_reg);
            end
            ST_DIFF:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({pa_reg - pb_reg, 16'h0000});
                div_req.divisor  = d_reg;
            end
            ST_UPDATE:
            begin
                mem_we         = 1'b1;
                wdata.sum      = '0;
                wdata.sq       = '0;
                wdata.cnt      = '0;
                wdata.mean_min = mn_new;
                wdata.mean_max = mx_new;
                wdata.std_min  = sn_new;
                wdata.std_max  = sx_new;
            end
            ST_OUT:    load = !out_valid_reg || result.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
            begin
                vld_reg[ent_reg.pair[PAIR_AW-1:0]] <= 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stat_mem[ent_reg.pair[PAIR_AW-1:0]] <= wdata;
        end
        if (state_reg == ST_READ)
        begin
            rec_reg     <= stat_mem[ent_reg.pair[PAIR_AW-1:0]];
            rec_vld_reg <= vld_reg[ent_reg.pair[PAIR_AW-1:0]];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    ent_reg <= head;
                end
            end
            ST_EXEC:
            begin
                n_reg    <= cnt_new;
                s_reg    <= sum_new;
                q_reg    <= sq_new;
                mn_reg   <= rec_eff.mean_min;
                mx_reg   <= rec_eff.mean_max;
                sn_reg   <= rec_eff.std_min;
                sx_reg   <= rec_eff.std_max;
                mean_reg <= (ent_reg.op == OP_READ) ? '0 : Q_NONE;
                std_reg  <= (ent_reg.op == OP_READ) ? '0 : Q_NONE;
                kind_reg <= (ent_reg.op == OP_READ) ? KIND_SUMMARY : KIND_STATS;
            end
            ST_MEAN:
            begin
                if (div_rsp.done)
                begin
                    mean_reg <= sat_q(div_rsp.quotient);
                end
            end
            ST_MUL:
            begin
                pa_reg <= n_reg * q_reg;
                pb_reg <= s_reg * s_reg;
                d_reg  <= n_reg * (n_reg - 1'b1);
            end
            ST_VAR:
            begin
                if (div_rsp.done)
                begin
                    v_reg    <= div_rsp.quotient;
                    root_reg <= '0;
                    bit_reg  <= DIV_W'(1) << (DIV_W - 2);
                end
            end
            ST_SQRT:
            begin
                if (root_ge)
                begin
                    v_reg    <= v_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    std_reg <= sat_q(root_ge ? (root_reg >> 1) + bit_reg : root_reg >> 1);
                end
            end
            ST_UPDATE:
            begin
                mn_reg <= mn_new;
                mx_reg <= mx_new;
                sn_reg <= sn_new;
                sx_reg <= sx_new;
            end
            default:   ;
        endcase
    end

    // Output register; an extreme pair that was never set reads as none.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result.result_kind <= kind_reg;
            result.out_gain    <= ent_reg.gain;
            result.out_channel <= ent_reg.channel;
            result.mean_value  <= mean_reg;
            result.std_value   <= std_reg;
            result.mean_min    <= (mn_reg > mx_reg) ? Q_NONE : mn_reg;
            result.mean_max    <= (mn_reg > mx_reg) ? Q_NONE : mx_reg;
            result.std_min     <= (sn_reg > sx_reg) ? Q_NONE : sn_reg;
            result.std_max     <= (sn_reg > sx_reg) ? Q_NONE : sx_reg;
        end
    end

    assign result.valid = out_valid_reg;

    `CMSM_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `CMSM_ASSERT_IMP(a_pop_idle, pop, state_reg == ST_IDLE, "item popped outside idle")
    `CMSM_ASSERT_IMP(a_we_state, mem_we, state_reg == ST_EXEC || state_reg == ST_UPDATE,
                     "memory written in wrong state")

endmodule

>>> design/channel_sample_mean_std_monitor_unit.sv
// ----------------------------------------------------------------------------
// channel_sample_mean_std_monitor_unit
// Per gain and channel record mean, standard deviation and running extremes.
// ----------------------------------------------------------------------------
// The stream port takes one item per cycle into a four-entry queue while the
// queue has room; ignored items (bad address, disabled pair, samples outside
// the window or range that do not close a record) are absorbed, not queued.
// The back end handles one queued item at a time: a sample that does not
// close its record takes the idle, read and execute states, a read command
// those plus the output state and its handshake. A closing sample runs the
// mean and then the variance through the shared one-bit-per-cycle divider
// and then the 28-step square root; with fewer than two good samples the
// variance and root are skipped. Statistics live in one memory of
// NUM_GAINS*NUM_CHANNELS records with a valid bit per record, so no clearing
// pass follows reset. Results leave through a registered output stage; the
// mean and deviation are signed Q12.8, -256 meaning none. Configuration
// writes are always ready and must be made only while the block is idle.
// ----------------------------------------------------------------------------
module channel_sample_mean_std_monitor_unit #(
    parameter int NUM_CHANNELS = cmsm_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_GAINS    = cmsm_pkg::NUM_GAINS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cmsm_in_if.sink     stream,
    cmsm_cfg_if.sink    cfg,
    cmsm_out_if.source  result
);
    import cmsm_pkg::*;

    // Classified items travel from the front to the back end through the queue.
    logic         push, full, pop, empty;
    queue_entry_t push_data, head;

    cmsm_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_GAINS    (NUM_GAINS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    cmsm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // The back end owns the statistics memory, the divider and the root unit.
    cmsm_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_GAINS    (NUM_GAINS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Channel statistics monitor testbench
// Streams sample records and read commands into the monitor and compares
// every result item, field by field, with a model of the per gain and
// channel sums, record mean and deviation, and running extremes kept here.
// ----------------------------------------------------------------------------
module tb;
    import cmsm_pkg::*;

    localparam int PAIRS       = 96;
    localparam int CHANS       = 48;
    localparam int SETTLE      = 400;     // covers the longest closing record
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1650;

    // One expected result item.
    typedef struct {
        logic     kind;
        logic     gain;
        int       chan;
        int       mean;
        int       sdev;
        int       mmin;
        int       mmax;
        int       smin;
        int       smax;
    } stat_result_t;

    logic clk;
    logic rst_n;

    cmsm_in_if  stream ();
    cmsm_out_if result ();
    cmsm_cfg_if cfg ();

    channel_sample_mean_std_monitor_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream.sink),
        .cfg    (cfg.sink),
        .result (result.source)
    );

    // Model of the monitor's configuration and per pair statistics.
    logic [1:0]      gain_mask;
    logic [47:0]     chan_mask;
    int              win_first;
    int              win_limit;
    longint unsigned pair_sum [PAIRS];
    longint unsigned pair_sq  [PAIRS];
    int              pair_cnt [PAIRS];
    int              pair_mean_lo [PAIRS];
    int              pair_mean_hi [PAIRS];
    int              pair_sd_lo   [PAIRS];
    int              pair_sd_hi   [PAIRS];

    stat_result_t pending_stats [$];

    int  mismatches;
    int  items_sent;
    int  live_items;
    int  results_seen;
    int  records_closed;
    int  reads_done;
    int  cycles;
    bit  tx_calm;
    bit  hold_req;
    int  hold_left;
    bit  rx_calm;
    int  rx_mode_left;

    // Clock and cycle watchdog.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Integer square root, rounding down.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic int clip_q(input longint unsigned v);
        return (v > 64'd1048575) ? 1048575 : int'(v);
    endfunction

    task automatic reset_model();
        gain_mask = 2'b11;
        chan_mask = '1;
        win_first = 0;
        win_limit = 128;
        for (int i = 0; i < PAIRS; i++)
        begin
            pair_sum[i] = 0;
            pair_sq[i]  = 0;
            pair_cnt[i] = 0;
            pair_mean_lo[i] = 1048575;
            pair_mean_hi[i] = -256;
            pair_sd_lo[i]   = 1048575;
            pair_sd_hi[i]   = -256;
        end
    endtask

    // Work out the effect of one accepted item; queue its result if any.
    // Returns 0 for an out-of-range channel or a sample to a disabled pair, else 1.
    function automatic bit track_item(input logic cmd, input logic g, input int ch,
                                      input int idx, input int val, input logic last);
        stat_result_t    r;
        int              p;
        longint unsigned n;
        longint unsigned s;
        longint unsigned q;
        longint unsigned num;
        longint unsigned den;
        longint unsigned v;
        if (ch >= CHANS)
            return 0;
        p = int'(g) * CHANS + ch;
        r.gain = g;
        r.chan = ch;
        if (cmd == CMD_READ)
        begin
            r.kind = KIND_SUMMARY;
            r.mean = 0;
            r.sdev = 0;
            reads_done++;
        end
        else
        begin
            if (!gain_mask[g] || !chan_mask[ch])
                return 0;
            if (idx >= win_first && idx < win_limit && val >= 0 && val < SAMPLE_LIMIT
                && pair_cnt[p] < MAX_WINDOW)
            begin
                pair_sum[p] += longint'(val);
                pair_sq[p]  += longint'(val) * longint'(val);
                pair_cnt[p] += 1;
            end
            if (!last)
                return 1;
            n = pair_cnt[p];
            s = pair_sum[p];
            q = pair_sq[p];
            r.kind = KIND_STATS;
            r.mean = (n == 0) ? -256 : clip_q((s << 8) / n);
            if (n < 2)
                r.sdev = -256;
            else
            begin
                num = n * q - s * s;
                den = n * (n - 1);
                v = (num / den) * 65536 + ((num % den) * 65536) / den;
                r.sdev = clip_q(int_sqrt(v));
            end
            if (r.mean < pair_mean_lo[p]) pair_mean_lo[p] = r.mean;
            if (r.mean > pair_mean_hi[p]) pair_mean_hi[p] = r.mean;
            if (r.sdev < pair_sd_lo[p])   pair_sd_lo[p]   = r.sdev;
            if (r.sdev > pair_sd_hi[p])   pair_sd_hi[p]   = r.sdev;
            pair_sum[p] = 0;
            pair_sq[p]  = 0;
            pair_cnt[p] = 0;
            records_closed++;
        end
        // A pair whose minimum is still above its maximum has no extremes yet.
        r.mmin = (pair_mean_lo[p] > pair_mean_hi[p]) ? -256 : pair_mean_lo[p];
        r.mmax = (pair_mean_lo[p] > pair_mean_hi[p]) ? -256 : pair_mean_hi[p];
        r.smin = (pair_sd_lo[p] > pair_sd_hi[p]) ? -256 : pair_sd_lo[p];
        r.smax = (pair_sd_lo[p] > pair_sd_hi[p]) ? -256 : pair_sd_hi[p];
        pending_stats.push_back(r);
        return 1;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and hold it until the monitor takes it. Valid is left
    // high when the next item follows straight away.
    task automatic send_item(input logic cmd, input logic g, input logic [5:0] ch,
                             input logic [6:0] idx, input logic signed [15:0] val,
                             input logic last);
        int gap;
        stream.valid        <= 1'b1;
        stream.command      <= cmd;
        stream.gain_select  <= g;
        stream.channel      <= ch;
        stream.sample_index <= idx;
        stream.sample_value <= val;
        stream.last_sample  <= last;
        do
            @(posedge clk);
        while (!stream.ready);
        items_sent++;
        if (track_item(cmd, g, int'(ch), int'(idx), int'(val), last))
            live_items++;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            stream.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every expected result, then let queued
    // samples that produce no result finish as well.
    task automatic drain();
        stream.valid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [47:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_GAIN_EN:   gain_mask = value[1:0];
            CFG_CHAN_EN:   chan_mask = value;
            CFG_WIN_START: win_first = int'(value[6:0]);
            CFG_WIN_END:   win_limit = int'(value[7:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] gm, input logic [47:0] cm,
                              input int ws, input int we);
        write_reg(CFG_GAIN_EN, 48'(gm));
        write_reg(CFG_CHAN_EN, cm);
        write_reg(CFG_WIN_START, 48'(ws));
        write_reg(CFG_WIN_END, 48'(we));
    endtask

    // A sample value: mostly in range around a centre with a random spread,
    // sometimes any 16-bit pattern at all.
    function automatic logic signed [15:0] pick_value(input int centre, input int spread);
        int v;
        if ($urandom_range(0, 19) == 0)
            return 16'($urandom);
        v = centre + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 16'(v);
    endfunction

    // One record of one pair: consecutive indices from base, last on the end.
    task automatic send_record(input logic g, input logic [5:0] ch, input int len,
                               input int base);
        int centre;
        int spread;
        centre = $urandom_range(0, 4095);
        spread = ($urandom_range(0, 3) == 0) ? 2048 : $urandom_range(0, 64);
        for (int k = 0; k < len; k++)
            send_item(CMD_SAMPLE, g, ch, 7'((base + k) % 128),
                      pick_value(centre, spread), k == len - 1);
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each accepted result, then choose ready for the
    // next cycle. A hold request keeps ready low for a counted stretch.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stat_result_t e;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            hold_left    = 0;
            rx_mode_left = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                results_seen++;
                if (pending_stats.size() == 0)
                begin
                    $display("%0t: result with none expected, channel %0d", $time,
                             result.out_channel);
                    mismatches++;
                end
                else
                begin
                    e = pending_stats.pop_front();
                    check_field("result_kind", int'(e.kind), int'(result.result_kind));
                    check_field("out_gain", int'(e.gain), int'(result.out_gain));
                    check_field("out_channel", e.chan, int'(result.out_channel));
                    check_field("mean_value", e.mean, int'(result.mean_value));
                    check_field("std_value", e.sdev, int'(result.std_value));
                    check_field("mean_min", e.mmin, int'(result.mean_min));
                    check_field("mean_max", e.mmax, int'(result.mean_max));
                    check_field("std_min", e.smin, int'(result.std_min));
                    check_field("std_max", e.smax, int'(result.std_max));
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 600;
            end
            if (rx_mode_left == 0)
            begin
                rx_calm      = ($urandom_range(0, 3) == 0);
                rx_mode_left = $urandom_range(50, 400);
            end
            else
                rx_mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (rx_calm)
                result.ready <= 1'b1;
            else if ($urandom_range(0, 99) < 4)
            begin
                // A long stall, counted here.
                hold_left = $urandom_range(10, 60);
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, read commands and the address special cases.
    task automatic test_directed();
        // Read of a pair that has never closed a record: no extremes yet.
        send_item(CMD_READ, 1'b0, 6'd0, 7'd0, 16'sd0, 1'b0);
        // Value extremes at index extremes; only 0 and 4095 are good.
        send_item(CMD_SAMPLE, 1'b0, 6'd0, 7'd0, -16'sd32768, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 6'd0, 7'd1, -16'sd1, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 6'd0, 7'd2, 16'sd0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 6'd0, 7'd3, 16'sd4096, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 6'd0, 7'd4, 16'sd32767, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 6'd0, 7'd127, 16'sd4095, 1'b1);
        // A single good sample: mean only, no deviation.
        send_item(CMD_SAMPLE, 1'b1, 6'd47, 7'd127, 16'sd4095, 1'b1);
        // A record with no good sample at all.
        send_item(CMD_SAMPLE, 1'b1, 6'd1, 7'd5, -16'sd5, 1'b1);
        // Out of range channels are ignored, reads included.
        send_item(CMD_SAMPLE, 1'b0, 6'd48, 7'd0, 16'sd100, 1'b1);
        send_item(CMD_READ, 1'b1, 6'd63, 7'd0, 16'sd0, 1'b0);
        // Reads ignore their sample fields.
        send_item(CMD_READ, 1'b0, 6'd0, 7'd127, -16'sd1, 1'b1);
        send_item(CMD_READ, 1'b1, 6'd47, 7'd64, 16'sd4095, 1'b0);
        send_item(CMD_READ, 1'b1, 6'd1, 7'd0, 16'sd0, 1'b0);
        drain();
    endtask

    // Disabled gain and channel, window edges and an empty window.
    task automatic test_config_cases();
        set_config(2'b01, 48'hFFFF_FFFF_FFFE, 0, 128);
        send_record(1'b1, 6'd5, 4, 0);           // gain disabled
        send_record(1'b0, 6'd0, 4, 0);           // channel disabled
        send_item(CMD_READ, 1'b1, 6'd47, 7'd0, 16'sd0, 1'b0);
        send_record(1'b0, 6'd2, 6, 0);
        drain();
        set_config(2'b10, 48'h8000_0000_0001, 127, 128);
        send_record(1'b1, 6'd47, 5, 124);        // only index 127 counts
        send_record(1'b1, 6'd0, 3, 10);          // last outside the window
        send_record(1'b0, 6'd0, 3, 0);           // gain disabled
        drain();
        set_config(2'b00, 48'h0, 0, 0);
        send_record(1'b0, 6'd3, 3, 0);
        send_item(CMD_READ, 1'b0, 6'd3, 7'd0, 16'sd0, 1'b0);
        drain();
        set_config(2'b11, '1, 64, 32);           // empty window
        send_record(1'b0, 6'd9, 8, 30);
        drain();
        set_config(2'b11, '1, 0, 128);
    endtask

    // Samples up to and beyond what a record can hold.
    task automatic test_record_overflow();
        tx_calm = 1'b1;
        send_record(1'b0, 6'd20, 140, 0);
        send_record(1'b1, 6'd21, 128, 0);
        tx_calm = 1'b0;
        drain();
    endtask

    // Results held back for a long stretch while items keep coming.
    task automatic test_backpressure();
        hold_req = 1'b1;
        tx_calm  = 1'b1;
        for (int k = 0; k < 12; k++)
            send_record(1'(k), 6'(k), 2, 0);
        for (int k = 0; k < 6; k++)
            send_item(CMD_READ, 1'(k), 6'(k), 7'd0, 16'sd0, 1'b0);
        tx_calm = 1'b0;
        drain();
    endtask

    // Random phases: mostly whole records with random content, some reads, the rest noise.
    task automatic test_random();
        int target;
        int phase;
        int r;
        phase = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if (phase % 4 == 0)
                set_config(2'($urandom_range(1, 3)),
                           ($urandom_range(0, 1) == 0) ? '1 : {16'($urandom), 32'($urandom)},
                           ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 127),
                           ($urandom_range(0, 1) == 0) ? 128 : $urandom_range(0, 128));
            for (int n = 0; n < 40 && items_sent < target; n++)
            begin
                tx_calm = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 9);
                if (r < 7)
                    send_record(1'($urandom), 6'($urandom_range(0, 47)),
                                ($urandom_range(0, 19) == 0) ? $urandom_range(60, 130)
                                                             : $urandom_range(1, 12),
                                $urandom_range(0, 127));
                else if (r < 9)
                    send_item(CMD_READ, 1'($urandom), 6'($urandom_range(0, 47)),
                              7'($urandom), 16'($urandom), 1'($urandom));
                else
                    send_item(1'($urandom), 1'($urandom), 6'($urandom), 7'($urandom),
                              16'($urandom), 1'($urandom));
            end
            tx_calm = 1'b0;
            phase++;
            drain();
        end
        set_config(2'b11, '1, 0, 128);
    endtask

    initial
    begin
        mismatches     = 0;
        items_sent     = 0;
        live_items     = 0;
        results_seen   = 0;
        records_closed = 0;
        reads_done     = 0;
        cycles         = 0;
        tx_calm        = 1'b0;
        hold_req       = 1'b0;
        rx_calm        = 1'b0;
        reset_model();
        rst_n               <= 1'b0;
        stream.valid        <= 1'b0;
        stream.command      <= CMD_SAMPLE;
        stream.gain_select  <= 1'b0;
        stream.channel      <= '0;
        stream.sample_index <= '0;
        stream.sample_value <= '0;
        stream.last_sample  <= 1'b0;
        cfg.valid           <= 1'b0;
        cfg.index           <= CFG_GAIN_EN;
        cfg.data            <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_cases();
        test_record_overflow();
        test_backpressure();
        test_random();

        $display("Sent %0d items (%0d handled), closed %0d records, %0d reads.",
                 items_sent, live_items, records_closed, reads_done);
        $display("Checked %0d results over several window and enable settings.",
                 results_seen);
        if (pending_stats.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_stats.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
